/* rtl/core/gpev_pkg.sv */
// Package: shared codes, constants and helpers for the gamepad event detector.
`default_nettype none

package gpev_pkg;

    localparam int BUTTON_COUNT = 16;
    localparam int BTN_W        = 16;

    localparam logic [BTN_W-1:0] C_BTN_MASK =
        (BUTTON_COUNT >= BTN_W) ? {BTN_W{1'b1}} : BTN_W'((1 << BUTTON_COUNT) - 1);

    localparam int DZ_W    = 15;
    localparam int DZ_SQ_W = 2 * DZ_W;
    localparam int CFG_W   = 15;

    localparam logic [DZ_W-1:0] C_DEADZONE_RESET  = 15'd3200;
    localparam logic [7:0]      C_THRESHOLD_RESET = 8'd30;
    localparam logic [7:0]      C_SKIP_RESET      = 8'd60;

    localparam logic [DZ_SQ_W-1:0] C_DZ_SQ_RESET =
        DZ_SQ_W'(C_DEADZONE_RESET) * DZ_SQ_W'(C_DEADZONE_RESET);

    typedef enum logic [1:0] {
        KIND_DOWN    = 2'd0,
        KIND_UP      = 2'd1,
        KIND_OUTCOME = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OUT_INACTIVE = 2'd0,
        OUT_ACTIVE   = 2'd1,
        OUT_NO_NEWS  = 2'd2,
        OUT_ERROR    = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_CONN = 2'd1,
        ST_FAIL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_DEADZONE  = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_SKIP      = 2'd2
    } t_cfg_reg;

    function automatic logic [3:0] lowest_index(input logic [BTN_W-1:0] m);
        logic [3:0] idx;
        idx = 4'd0;
        for (int b = BTN_W - 1; b >= 0; b--) begin
            if (m[b]) begin
                idx = 4'(b);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gamepad_event_detector.sv */
// Gamepad event detector: poll decode, button edge events and deadzone test.
// The first result word is registered once the poll leaves the input register.
// Throughput with i_ready high: one poll per cycle when it yields one word; a poll
// with k button changes holds the output register for k+1 words, one per cycle.
// The input register and the output register with its pending-event mask
// set the rate; one more poll waits in the input register while the output drains.
// Reset: synchronous, active low; clears state, registers to defaults, no words.
`default_nettype none

module gamepad_event_detector
    import gpev_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_read_status,
    input  wire logic [31:0]        i_packet_number,
    input  wire logic [BTN_W-1:0]   i_buttons,
    input  wire logic signed [15:0] i_left_x,
    input  wire logic signed [15:0] i_left_y,
    input  wire logic signed [15:0] i_right_x,
    input  wire logic signed [15:0] i_right_y,
    input  wire logic [7:0]         i_left_trigger,
    input  wire logic [7:0]         i_right_trigger,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_kind,
    output logic [3:0]              o_button,
    output logic [1:0]              o_outcome,
    output logic                    o_last
);

    logic [DZ_SQ_W-1:0] r_dz_sq;
    logic [7:0]         r_threshold;
    logic [7:0]         r_skip_reload;

    logic [7:0]         r_skip, n_skip;
    logic [31:0]        r_last_packet, n_last_packet;
    logic [BTN_W-1:0]   r_last_buttons, n_last_buttons;
    logic               r_moving, n_moving;

    logic               r_a_valid, n_a_valid;
    logic [1:0]         r_a_status;
    logic [31:0]        r_a_packet;
    logic [BTN_W-1:0]   r_a_buttons;
    logic signed [15:0] r_a_lx, r_a_ly, r_a_rx, r_a_ry;
    logic [7:0]         r_a_lt, r_a_rt;

    logic               r_o_valid, n_o_valid;
    t_kind              r_o_kind, n_o_kind;
    logic [3:0]         r_o_button, n_o_button;
    t_outcome           r_o_outcome, n_o_outcome;
    logic               r_o_last, n_o_last;
    logic [BTN_W-1:0]   r_rest, n_rest;
    logic [BTN_W-1:0]   r_b_buttons, n_b_buttons;
    t_outcome           r_b_outcome, n_b_outcome;

    logic [DZ_SQ_W-1:0] cfg_sq;
    logic               a_adv;
    logic               b_free;
    logic               out_take;
    logic signed [31:0] lx2, ly2, rx2, ry2;
    logic [31:0]        left_mag, right_mag;
    logic               stick_moving;
    logic               trig_moving;
    logic [BTN_W-1:0]   diff;
    logic [BTN_W-1:0]   changed;
    t_outcome           dec_outcome;
    logic [3:0]         rest_idx;
    logic [3:0]         chg_idx;

    assign cfg_sq = DZ_SQ_W'(i_cfg_wdata[DZ_W-1:0]) * DZ_SQ_W'(i_cfg_wdata[DZ_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz_sq       <= C_DZ_SQ_RESET;
            r_threshold   <= C_THRESHOLD_RESET;
            r_skip_reload <= C_SKIP_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DEADZONE:  r_dz_sq       <= cfg_sq;
                CFG_THRESHOLD: r_threshold   <= i_cfg_wdata[7:0];
                CFG_SKIP:      r_skip_reload <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign out_take = r_o_valid && i_ready;
    assign b_free   = !r_o_valid || (i_ready && r_o_last);
    assign a_adv    = r_a_valid && b_free;
    assign o_ready  = !r_a_valid || b_free;

    assign lx2 = r_a_lx * r_a_lx;
    assign ly2 = r_a_ly * r_a_ly;
    assign rx2 = r_a_rx * r_a_rx;
    assign ry2 = r_a_ry * r_a_ry;
    assign left_mag  = unsigned'(lx2) + unsigned'(ly2);
    assign right_mag = unsigned'(rx2) + unsigned'(ry2);
    assign stick_moving = (left_mag > 32'(r_dz_sq)) || (right_mag > 32'(r_dz_sq));
    assign trig_moving  = (r_a_lt > r_threshold) || (r_a_rt > r_threshold);

    assign diff     = r_last_buttons ^ r_a_buttons;
    assign rest_idx = lowest_index(r_rest);

    always_comb begin
        n_skip         = r_skip;
        n_last_packet  = r_last_packet;
        n_last_buttons = r_last_buttons;
        n_moving       = r_moving;
        changed        = '0;
        dec_outcome    = OUT_INACTIVE;
        if (r_skip != 8'd0) begin
            n_skip = r_skip - 8'd1;
        end else if (r_a_status == ST_NOT_CONN) begin
            n_skip = r_skip_reload;
        end else if (r_a_status != ST_OK) begin
            dec_outcome = OUT_ERROR;
        end else if (r_a_packet != r_last_packet) begin
            n_last_packet  = r_a_packet;
            n_last_buttons = r_a_buttons;
            changed        = diff & C_BTN_MASK;
            if (diff == '0) begin
                n_moving = stick_moving || trig_moving;
            end
            dec_outcome = OUT_ACTIVE;
        end else begin
            dec_outcome = r_moving ? OUT_ACTIVE : OUT_NO_NEWS;
        end
        chg_idx = lowest_index(changed);
    end

    always_comb begin
        n_o_valid   = r_o_valid;
        n_o_kind    = r_o_kind;
        n_o_button  = r_o_button;
        n_o_outcome = r_o_outcome;
        n_o_last    = r_o_last;
        n_rest      = r_rest;
        n_b_buttons = r_b_buttons;
        n_b_outcome = r_b_outcome;
        if (a_adv) begin
            n_o_valid   = 1'b1;
            n_b_buttons = r_a_buttons;
            n_b_outcome = dec_outcome;
            if (changed != '0) begin
                n_o_kind    = r_a_buttons[chg_idx] ? KIND_DOWN : KIND_UP;
                n_o_button  = chg_idx;
                n_o_outcome = OUT_INACTIVE;
                n_o_last    = 1'b0;
                n_rest      = changed & (changed - BTN_W'(1));
            end else begin
                n_o_kind    = KIND_OUTCOME;
                n_o_button  = 4'd0;
                n_o_outcome = dec_outcome;
                n_o_last    = 1'b1;
                n_rest      = '0;
            end
        end else if (out_take && !r_o_last) begin
            if (r_rest != '0) begin
                n_o_kind   = r_b_buttons[rest_idx] ? KIND_DOWN : KIND_UP;
                n_o_button = rest_idx;
                n_rest     = r_rest & (r_rest - BTN_W'(1));
            end else begin
                n_o_kind    = KIND_OUTCOME;
                n_o_button  = 4'd0;
                n_o_outcome = r_b_outcome;
                n_o_last    = 1'b1;
            end
        end else if (out_take) begin
            n_o_valid = 1'b0;
        end
    end

    assign n_a_valid = (i_valid && o_ready) || (r_a_valid && !a_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid      <= 1'b0;
            r_o_valid      <= 1'b0;
            r_o_last       <= 1'b0;
            r_rest         <= '0;
            r_skip         <= 8'd0;
            r_last_packet  <= 32'd0;
            r_last_buttons <= '0;
            r_moving       <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_o_valid <= n_o_valid;
            r_o_last  <= n_o_last;
            r_rest    <= n_rest;
            if (a_adv) begin
                r_skip         <= n_skip;
                r_last_packet  <= n_last_packet;
                r_last_buttons <= n_last_buttons;
                r_moving       <= n_moving;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_status  <= i_read_status;
            r_a_packet  <= i_packet_number;
            r_a_buttons <= i_buttons;
            r_a_lx      <= i_left_x;
            r_a_ly      <= i_left_y;
            r_a_rx      <= i_right_x;
            r_a_ry      <= i_right_y;
            r_a_lt      <= i_left_trigger;
            r_a_rt      <= i_right_trigger;
        end
        r_o_kind    <= n_o_kind;
        r_o_button  <= n_o_button;
        r_o_outcome <= n_o_outcome;
        r_b_buttons <= n_b_buttons;
        r_b_outcome <= n_b_outcome;
    end

    assign o_valid   = r_o_valid;
    assign o_kind    = r_o_kind;
    assign o_button  = r_o_button;
    assign o_outcome = r_o_outcome;
    assign o_last    = r_o_last;

`ifndef SYNTHESIS
    a_last_is_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_kind == KIND_OUTCOME)
        else $error("final word is not an outcome");

    a_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> (o_kind == KIND_DOWN || o_kind == KIND_UP)
            && o_outcome == OUT_INACTIVE)
        else $error("event word carries bad kind or outcome");

    a_poll_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("poll dropped before its outcome");

    a_skip_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv && r_skip != 8'd0 |=> r_skip == $past(r_skip) - 8'd1)
        else $error("skip countdown did not decrement");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_adv |=> r_a_valid)
        else $error("pending poll lost");
`endif

endmodule

`default_nettype wire
